// ----- hdl/lhf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lhf_pkg;

  // Operation codes carried in the op field of a request.
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Largest value a hit counter reaches.
  localparam logic [1:0] CNT_MAX = 2'd3;

  // Packed field widths of the stream data words.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Work that the front hands to the back.
  typedef enum logic [1:0] {
    CMD_COUNT,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       in_range;
    logic [1:0] rd_end;
  } lhf_cmd_t;

  localparam int CMD_W = $bits(lhf_cmd_t);

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW
  } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/lone_hit_flagger_core.sv -----
// Lone hit flagger: per-plane hit counting and isolation flags for tracker clusters.
// Input stream (in_*): one request per cluster, with op, tower, layer, view and end.
// A count request bumps the 2-bit counter of the cluster's readout end (saturating
// at 3); a query request returns one result on the output stream (out_*) with the
// alone and alone_on_end flags; a clear request zeroes every counter.
// Count and clear requests produce no result. Requests with op 3, and counts on
// no end or on an out-of-range plane, are accepted and dropped.
// Requests pass a classifying front, then a two-entry queue, then a back end that
// does one read-modify-write on the counter RAM. A count or query occupies the back
// end for a RAM read, then an update or result, and the back end takes no new request
// from the queue until it is done with the last; with the queue empty and the output
// free, a query sets out_tvalid once it has passed the queue, the RAM read and BK_RMW.
// A clear leaves the queue and then walks the RAM one plane per cycle, over all
// NUM_TOWERS * NUM_LAYERS * 2 planes (576 at the defaults).
// After reset the same clearing pass runs before the first request is processed;
// requests are still accepted into the queue meanwhile, up to its depth.
// When the receiver holds out_tready low, the result stays in the output register,
// the back end waits on the next query, and the queue fills, then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module lone_hit_flagger_core #(
  parameter int NUM_TOWERS = 16,
  parameter int NUM_LAYERS = 18
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: op[1:0], tower[5:2], layer[10:6], view[11], readout_end[13:12].
  input  wire logic [lhf_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // Fields from bit 0: alone[0], alone_on_end[1].
  output logic      [lhf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Each RAM word holds both end counters of one plane: end 0 in [1:0], end 1 in [3:2].
  localparam int PLANE_DEPTH = NUM_TOWERS * NUM_LAYERS * 2;
  localparam int PLANE_AW    = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int Q_W         = lhf_pkg::CMD_W + PLANE_AW;

  logic                push_valid, push_ready;
  lhf_pkg::lhf_cmd_t   push_cmd;
  logic [PLANE_AW-1:0] push_addr;
  logic                pop_valid, pop_ready;
  logic [Q_W-1:0]      pop_data;
  lhf_pkg::lhf_cmd_t   pop_cmd;
  logic [PLANE_AW-1:0] pop_addr;

  logic                ram_we, ram_re;
  logic [PLANE_AW-1:0] ram_waddr, ram_raddr;
  logic [3:0]          ram_wdata, ram_rdata;

  // The front decodes the request and forms the plane address.
  lhf_front #(
    .NUM_TOWERS (NUM_TOWERS),
    .NUM_LAYERS (NUM_LAYERS),
    .PLANE_AW   (PLANE_AW)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr)
  );

  // The queue lets the front keep accepting while the back end is busy.
  lhf_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_addr}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cmd  = pop_data[Q_W-1:PLANE_AW];
  assign pop_addr = pop_data[PLANE_AW-1:0];

  // The back end owns the counter RAM and the result register.
  lhf_back #(
    .PLANE_DEPTH (PLANE_DEPTH),
    .PLANE_AW    (PLANE_AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .pop_addr   (pop_addr),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lhf_ram #(
    .WIDTH (4),
    .DEPTH (PLANE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ----- hdl/lhf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lhf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 576
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lhf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lhf_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  // Two entries: the front can run up to two requests ahead of the back.
  localparam int DEPTH = 2;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != 2'(DEPTH));
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lhf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lhf_front #(
  parameter int NUM_TOWERS = 16,
  parameter int NUM_LAYERS = 18,
  parameter int PLANE_AW   = 10
) (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lhf_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output lhf_pkg::lhf_cmd_t                   push_cmd,
  output logic      [PLANE_AW-1:0]            push_addr
);

  logic [1:0] op;
  logic [3:0] tower;
  logic [4:0] layer;
  logic       view;
  logic [1:0] rd_end;
  logic       in_range;
  logic       keep;

  assign op     = in_tdata[1:0];
  assign tower  = in_tdata[5:2];
  assign layer  = in_tdata[10:6];
  assign view   = in_tdata[11];
  assign rd_end = in_tdata[13:12];

  assign in_range = (32'(tower) < NUM_TOWERS) && (32'(layer) < NUM_LAYERS);

  // Requests that change nothing and return nothing are taken and dropped here.
  always_comb begin
    push_cmd.in_range = in_range;
    push_cmd.rd_end   = rd_end;
    push_cmd.kind     = lhf_pkg::CMD_QUERY;
    keep              = 1'b0;
    case (op)
      lhf_pkg::OP_COUNT: begin
        push_cmd.kind = lhf_pkg::CMD_COUNT;
        keep          = in_range && !rd_end[1];
      end
      lhf_pkg::OP_QUERY: begin
        push_cmd.kind = lhf_pkg::CMD_QUERY;
        keep          = 1'b1;
      end
      lhf_pkg::OP_CLEAR: begin
        push_cmd.kind = lhf_pkg::CMD_CLEAR;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Dense plane address; out-of-range planes read address zero and are masked later.
  assign push_addr = in_range
                   ? PLANE_AW'((32'(tower) * NUM_LAYERS + 32'(layer)) * 2 + 32'(view))
                   : '0;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid & keep;

endmodule
`default_nettype wire

// ----- hdl/lhf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lhf_back #(
  parameter int PLANE_DEPTH = 576,
  parameter int PLANE_AW    = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            pop_valid,
  output logic                                 pop_ready,
  input  wire lhf_pkg::lhf_cmd_t               pop_cmd,
  input  wire logic [PLANE_AW-1:0]             pop_addr,
  output logic                                 ram_we,
  output logic      [PLANE_AW-1:0]             ram_waddr,
  output logic      [3:0]                      ram_wdata,
  output logic                                 ram_re,
  output logic      [PLANE_AW-1:0]             ram_raddr,
  input  wire logic [3:0]                      ram_rdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [lhf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lhf_pkg::back_state_t state_r, state_nxt;
  logic [PLANE_AW-1:0]  clr_ptr_r, clr_ptr_nxt;
  lhf_pkg::lhf_cmd_t    cur_cmd_r, cur_cmd_nxt;
  logic [PLANE_AW-1:0]  cur_addr_r, cur_addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_flags_r, out_flags_nxt;

  logic [1:0] c0, c1, own, own_inc;
  logic [2:0] tot;
  logic       alone, alone_on_end;

  // Counts of the plane; an out-of-range plane reads as empty.
  assign c0      = cur_cmd_r.in_range ? ram_rdata[1:0] : 2'd0;
  assign c1      = cur_cmd_r.in_range ? ram_rdata[3:2] : 2'd0;
  assign tot     = {1'b0, c0} + {1'b0, c1};
  assign own     = cur_cmd_r.rd_end[0] ? c1 : c0;
  assign own_inc = (own == lhf_pkg::CNT_MAX) ? own : own + 2'd1;

  always_comb begin
    if (cur_cmd_r.rd_end[1]) begin
      alone        = (tot == 3'd0);
      alone_on_end = (tot == 3'd0);
    end else begin
      alone        = (tot == 3'd1);
      alone_on_end = (own == 2'd1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_ptr_nxt   = clr_ptr_r;
    cur_cmd_nxt   = cur_cmd_r;
    cur_addr_nxt  = cur_addr_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_flags_nxt = out_flags_r;
    pop_ready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cur_addr_r;
    ram_wdata     = cur_cmd_r.rd_end[0] ? {own_inc, c0} : {c1, own_inc};
    ram_re        = 1'b0;
    ram_raddr     = pop_addr;
    case (state_r)
      lhf_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr_r;
        ram_wdata = 4'd0;
        if (clr_ptr_r == PLANE_AW'(PLANE_DEPTH - 1)) begin
          clr_ptr_nxt = '0;
          state_nxt   = lhf_pkg::BK_IDLE;
        end else begin
          clr_ptr_nxt = clr_ptr_r + PLANE_AW'(1);
        end
      end
      lhf_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_cmd_nxt  = pop_cmd;
          cur_addr_nxt = pop_addr;
          if (pop_cmd.kind == lhf_pkg::CMD_CLEAR) begin
            clr_ptr_nxt = '0;
            state_nxt   = lhf_pkg::BK_CLEAR;
          end else begin
            ram_re    = 1'b1;
            state_nxt = lhf_pkg::BK_RMW;
          end
        end
      end
      lhf_pkg::BK_RMW: begin
        case (cur_cmd_r.kind)
          lhf_pkg::CMD_COUNT: begin
            ram_we    = 1'b1;
            state_nxt = lhf_pkg::BK_IDLE;
          end
          lhf_pkg::CMD_QUERY: begin
            // Wait here while the result register still holds an untaken result.
            if (!out_valid_r || out_tready) begin
              out_valid_nxt = 1'b1;
              out_flags_nxt = {alone_on_end, alone};
              state_nxt     = lhf_pkg::BK_IDLE;
            end
          end
          default: begin
            state_nxt = lhf_pkg::BK_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = lhf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lhf_pkg::BK_CLEAR;
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_cmd_r   <= cur_cmd_nxt;
    cur_addr_r  <= cur_addr_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lhf_pkg::OUT_TDATA_W - 2){1'b0}}, out_flags_r};

endmodule
`default_nettype wire

// ----- tb/tb_lone_hit_flagger_core.sv -----
`timescale 1ns / 1ps
module tb_lone_hit_flagger_core;

  localparam int NUM_TOWERS    = 16;
  localparam int NUM_LAYERS    = 18;
  localparam int PLANE_ENTRIES = NUM_TOWERS * NUM_LAYERS * 4;

  // Op 3 is accepted and dropped by the block.
  localparam logic [1:0] OP_NONE   = 2'd3;
  // Readout end codes beyond the two real ends.
  localparam logic [1:0] END_NONE  = 2'd2;
  localparam logic [1:0] END_SPARE = 2'd3;

  localparam int DIR_ROWS     = 25;
  localparam int TOTAL_REQS   = DIR_ROWS + 800;
  localparam int QUIET_AFTER  = TOTAL_REQS - 100;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 50;

  // Request word, op in the lowest bits.
  typedef struct packed {
    logic [1:0] ro_end;
    logic       view;
    logic [4:0] layer;
    logic [3:0] tower;
    logic [1:0] op;
  } hit_req_t;

  // Result word, alone in bit 0.
  typedef struct packed {
    logic alone_on_end;
    logic alone;
  } lone_flags_t;

  // One line of the directed table; want is used only when fixed is set.
  typedef struct packed {
    bit          fixed;
    lone_flags_t want;
    hit_req_t    req;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lhf_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [lhf_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow of the hit counters and the flags still owed by the block.
  logic [1:0]  plane_counts [PLANE_ENTRIES];
  lone_flags_t flag_queue [$];

  int err_cnt   = 0;
  int req_cnt   = 0;
  bit quiet     = 1'b0;
  bit idle_mode = 1'b1;
  bit hold_req  = 1'b0;

  lone_hit_flagger_core #(
    .NUM_TOWERS(NUM_TOWERS),
    .NUM_LAYERS(NUM_LAYERS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one accepted request to the shadow counters and works out its flags.
  task automatic model_request(input hit_req_t r, output bit has_flags,
                               output lone_flags_t f);
    int         base;
    int         idx;
    bit         in_plane;
    logic [2:0] c0;
    logic [2:0] c1;
    logic [2:0] tot;
    has_flags = 1'b0;
    f = '0;
    c0 = '0;
    c1 = '0;
    in_plane = (int'(r.tower) < NUM_TOWERS) && (int'(r.layer) < NUM_LAYERS);
    base = ((int'(r.tower) * NUM_LAYERS + int'(r.layer)) * 2 + int'(r.view)) * 2;
    case (r.op)
      lhf_pkg::OP_CLEAR: begin
        foreach (plane_counts[i]) plane_counts[i] = '0;
      end
      lhf_pkg::OP_COUNT: begin
        // Ends 2 and 3 and planes off the detector are not counted.
        if (in_plane && !r.ro_end[1]) begin
          idx = base + int'(r.ro_end[0]);
          if (plane_counts[idx] != lhf_pkg::CNT_MAX)
            plane_counts[idx] = plane_counts[idx] + 2'd1;
        end
      end
      lhf_pkg::OP_QUERY: begin
        if (in_plane) begin
          c0 = {1'b0, plane_counts[base]};
          c1 = {1'b0, plane_counts[base + 1]};
        end
        tot = c0 + c1;
        has_flags = 1'b1;
        if (r.ro_end[1]) begin
          // A query with no end is flagged only when the plane is empty.
          f.alone        = (tot == 3'd0);
          f.alone_on_end = (tot == 3'd0);
        end else begin
          f.alone        = (tot == 3'd1);
          f.alone_on_end = ((r.ro_end[0] ? c1 : c0) == 3'd1);
        end
      end
      default: ;
    endcase
  endtask

  // Offers one request, waits for it to be taken, then books its flags.
  task automatic send_req(input hit_req_t r, input bit fixed = 1'b0,
                          input lone_flags_t want = '0);
    bit          has_flags;
    lone_flags_t f;
    if (idle_mode && !quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(lhf_pkg::IN_TDATA_W - $bits(hit_req_t)){1'b0}}, r};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    model_request(r, has_flags, f);
    if (has_flags) flag_queue.push_back(fixed ? want : f);
    if (r.op != OP_NONE) req_cnt++;
  endtask

  function automatic hit_req_t rand_req();
    hit_req_t r;
    r.op     = 2'($urandom_range(0, 3));
    r.tower  = 4'($urandom_range(0, 15));
    r.layer  = 5'($urandom_range(0, 31));
    r.view   = 1'($urandom_range(0, 1));
    r.ro_end = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic dir_row_t dir_entry(logic [1:0] op, int tower, int layer,
                                         logic view, logic [1:0] ro_end,
                                         bit fixed = 1'b0, logic alone = 1'b0,
                                         logic alone_on_end = 1'b0);
    dir_row_t e;
    e.req.op             = op;
    e.req.tower          = 4'(tower);
    e.req.layer          = 5'(layer);
    e.req.view           = view;
    e.req.ro_end         = ro_end;
    e.fixed              = fixed;
    e.want.alone         = alone;
    e.want.alone_on_end  = alone_on_end;
    return e;
  endfunction

  // One event: an occasional clear, then clusters counted in a small patch of planes so
  // that counts pile up, then each cluster queried in shuffled order, with noise.
  task automatic send_event();
    hit_req_t counted [$];
    hit_req_t r;
    int       n;
    int       t0;
    int       l0;
    int       k;
    idle_mode = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) begin
      r = rand_req();
      r.op = lhf_pkg::OP_CLEAR;
      send_req(r);
    end
    n  = $urandom_range(1, 16);
    t0 = $urandom_range(0, NUM_TOWERS - 1);
    l0 = $urandom_range(0, NUM_LAYERS - 1);
    for (int i = 0; i < n; i++) begin
      r.op     = lhf_pkg::OP_COUNT;
      r.tower  = 4'((t0 + $urandom_range(0, 1)) % NUM_TOWERS);
      r.layer  = 5'(l0 + $urandom_range(0, 1));
      r.view   = 1'($urandom_range(0, 1));
      r.ro_end = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
      counted.push_back(r);
      send_req(r);
      if ($urandom_range(0, 9) == 0) send_req(rand_req());
    end
    while (counted.size() > 0) begin
      k = $urandom_range(0, counted.size() - 1);
      r = counted[k];
      counted.delete(k);
      r.op = lhf_pkg::OP_QUERY;
      if ($urandom_range(0, 7) == 0) r.ro_end = 2'($urandom_range(0, 3));
      send_req(r);
      if ($urandom_range(0, 9) == 0) send_req(rand_req());
    end
  endtask

  // Request side: directed table, then random events, then drain and verdict.
  initial begin
    dir_row_t dir_tab [DIR_ROWS];
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    foreach (plane_counts[i]) plane_counts[i] = '0;

    // Fresh store, corner planes, the no-end and spare-end codes.
    dir_tab[0]  = dir_entry(lhf_pkg::OP_QUERY, 0, 0, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
    dir_tab[1]  = dir_entry(lhf_pkg::OP_QUERY, 15, 17, 1'b1, END_NONE, 1'b1, 1'b1, 1'b1);
    dir_tab[2]  = dir_entry(lhf_pkg::OP_QUERY, 0, 0, 1'b0, END_SPARE, 1'b1, 1'b1, 1'b1);
    // One hit on end 1, looked at from end 1, end 0 and no end, then a hit on end 0.
    dir_tab[3]  = dir_entry(lhf_pkg::OP_COUNT, 15, 17, 1'b1, 2'd1);
    dir_tab[4]  = dir_entry(lhf_pkg::OP_QUERY, 15, 17, 1'b1, 2'd1);
    dir_tab[5]  = dir_entry(lhf_pkg::OP_QUERY, 15, 17, 1'b1, 2'd0);
    dir_tab[6]  = dir_entry(lhf_pkg::OP_QUERY, 15, 17, 1'b1, END_NONE);
    dir_tab[7]  = dir_entry(lhf_pkg::OP_COUNT, 15, 17, 1'b1, 2'd0);
    dir_tab[8]  = dir_entry(lhf_pkg::OP_QUERY, 15, 17, 1'b1, 2'd0);
    // Counts with no end must leave the plane alone.
    dir_tab[9]  = dir_entry(lhf_pkg::OP_COUNT, 15, 17, 1'b1, END_NONE);
    dir_tab[10] = dir_entry(lhf_pkg::OP_COUNT, 15, 17, 1'b1, END_SPARE);
    // Four hits on one end run the counter into saturation.
    dir_tab[11] = dir_entry(lhf_pkg::OP_COUNT, 3, 5, 1'b0, 2'd0);
    dir_tab[12] = dir_entry(lhf_pkg::OP_COUNT, 3, 5, 1'b0, 2'd0);
    dir_tab[13] = dir_entry(lhf_pkg::OP_COUNT, 3, 5, 1'b0, 2'd0);
    dir_tab[14] = dir_entry(lhf_pkg::OP_COUNT, 3, 5, 1'b0, 2'd0);
    dir_tab[15] = dir_entry(lhf_pkg::OP_QUERY, 3, 5, 1'b0, 2'd0);
    // A layer off the detector is never counted and always reads empty.
    dir_tab[16] = dir_entry(lhf_pkg::OP_COUNT, 2, 31, 1'b0, 2'd0);
    dir_tab[17] = dir_entry(lhf_pkg::OP_QUERY, 2, 31, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);
    dir_tab[18] = dir_entry(lhf_pkg::OP_QUERY, 2, 31, 1'b1, END_NONE, 1'b1, 1'b1, 1'b1);
    dir_tab[19] = dir_entry(OP_NONE, 9, 9, 1'b1, 2'd1);
    // After a clear the plane counted above is empty again.
    dir_tab[20] = dir_entry(lhf_pkg::OP_CLEAR, 0, 0, 1'b0, 2'd0);
    dir_tab[21] = dir_entry(lhf_pkg::OP_QUERY, 15, 17, 1'b1, 2'd1, 1'b1, 1'b0, 1'b0);
    dir_tab[22] = dir_entry(lhf_pkg::OP_COUNT, 0, 0, 1'b0, 2'd1);
    dir_tab[23] = dir_entry(lhf_pkg::OP_QUERY, 0, 0, 1'b0, 2'd1);
    dir_tab[24] = dir_entry(lhf_pkg::OP_QUERY, 0, 18, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);

    // Ask the result side for one long hold-off while requests keep coming.
    hold_req = 1'b1;
    while (req_cnt < TOTAL_REQS) begin
      quiet = (req_cnt >= QUIET_AFTER);
      send_event();
    end
    in_tvalid <= 1'b0;

    while (flag_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: checks every accepted result and drives out_tready.
  initial begin
    int          stall;
    lone_flags_t got;
    lone_flags_t want;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        got = lone_flags_t'(out_tdata[1:0]);
        if (flag_queue.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("unexpected result: alone=%0b alone_on_end=%0b",
                     got.alone, got.alone_on_end);
        end else begin
          want = flag_queue.pop_front();
          if (got.alone !== want.alone || got.alone_on_end !== want.alone_on_end) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("flag mismatch: expected alone=%0b alone_on_end=%0b, got %0b %0b",
                       want.alone, want.alone_on_end, got.alone, got.alone_on_end);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (idle_mode && !quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
